// ----- src/camera_ray_direction_macros.svh -----
// Assertion helpers for the camera ray direction block.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef CAMERA_RAY_DIRECTION_MACROS_SVH
`define CAMERA_RAY_DIRECTION_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define CRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define CRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/crd_pkg.sv -----
package crd_pkg;

	// Field widths and fixed-point format
	localparam int FRAC_BITS       = 14;
	localparam int COMPONENT_WIDTH = 16;
	localparam int N_COMP          = 3;
	localparam int VEC_W           = N_COMP * COMPONENT_WIDTH;
	localparam int TAN_W           = 16;
	localparam int SCR_W           = 16;
	localparam int CFG_IDX_W       = 3;

	// Datapath widths
	localparam int TX_W      = TAN_W + SCR_W;           // tan * screen position
	localparam int PROD_W    = COMPONENT_WIDTH + TX_W;  // axis component * scaled position
	localparam int SUM_W     = PROD_W + 1;              // sum of three terms
	localparam int WMAG_W    = SUM_W - 1;               // magnitude of the sum
	localparam int POS_W     = $clog2(WMAG_W);
	localparam int NORM_MSB  = 29;                      // leading one after scaling
	localparam int MAG_W     = NORM_MSB + 2;            // scaled magnitude, up to 2^30
	localparam int SH_W      = $clog2(NORM_MSB + 1);
	localparam int SQ_W      = 2 * MAG_W;
	localparam int ROOT_W    = MAG_W;
	localparam int NUM_W     = MAG_W + FRAC_BITS;
	localparam int QUO_W     = FRAC_BITS + 1;

	// Register reset values
	localparam logic [VEC_W-1:0] RST_FORWARD   = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0] RST_UP        = 48'h0000_4000_0000;
	localparam logic [VEC_W-1:0] RST_RIGHT     = 48'h0000_0000_4000;
	localparam logic [TAN_W-1:0] RST_HALF_W_TAN = 16'd13748;
	localparam logic [TAN_W-1:0] RST_HALF_H_TAN = 16'd9459;

	typedef logic [VEC_W-1:0] vec_t;
	typedef logic [TAN_W-1:0] tan_t;
	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
	typedef logic [MAG_W-1:0] mag_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORWARD    = 3'd0,
		REG_UP         = 3'd1,
		REG_RIGHT      = 3'd2,
		REG_HALF_W_TAN = 3'd3,
		REG_HALF_H_TAN = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		vec_t forward_vector;
		vec_t up_vector;
		vec_t right_vector;
		tan_t half_width_tan;
		tan_t half_height_tan;
	} cfg_t;

	// Scaled direction magnitudes with their signs
	typedef struct packed {
		mag_t [N_COMP-1:0] mag;
		logic [N_COMP-1:0] neg;
		logic              degen;
	} nvec_t;

	typedef struct packed {
		comp_t dir_x;
		comp_t dir_y;
		comp_t dir_z;
		logic  degenerate;
	} ray_t;

	// Pick one signed component out of a packed axis vector
	function automatic comp_t vec_comp(vec_t v, int unsigned i);
		return comp_t'(v[i*COMPONENT_WIDTH +: COMPONENT_WIDTH]);
	endfunction

endpackage

// ----- src/crd_if.sv -----
interface crd_screen_if;
	import crd_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SCR_W-1:0] screen_x;
	logic signed [SCR_W-1:0] screen_y;
	modport source (output valid, screen_x, screen_y, input ready);
	modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

interface crd_ray_if;
	import crd_pkg::*;
	logic  valid;
	logic  ready;
	comp_t dir_x;
	comp_t dir_y;
	comp_t dir_z;
	logic  degenerate;
	modport source (output valid, dir_x, dir_y, dir_z, degenerate, input ready);
	modport sink   (input valid, dir_x, dir_y, dir_z, degenerate, output ready);
endinterface

interface crd_cfg_if;
	import crd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [VEC_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/camera_ray_direction.sv -----
// Pinhole camera ray direction generator.
// screen: one normalized screen position (screen_x, screen_y) per transfer,
//   signed Q1.14. ray: one unit direction (dir_x, dir_y, dir_z) in signed
//   Q1.14 plus a degenerate flag per position, in the order taken.
// cfg: register writes (index, data); always ready. Write only while no
//   position is in flight. Index 0 forward, 1 up, 2 right axis (three signed
//   Q1.14 components, x in the low bits), 3 and 4 the horizontal and vertical
//   half-angle tangents (unsigned Q2.14). Other indexes are dropped.
// Throughput: one position per cycle while screen.ready is high.
// Pipeline: 58 register stages, among them the 31-stage square root and the
//   15-stage divider, one quotient bit per stage.
// Reset: all stages empty, axes forward (0,0,1), up (0,1,0), right (1,0,0),
//   tangents of 40 and 30 degrees.
// Stall: a result waits in the output register while ray.ready is low; one
//   more result is caught in a skid register, then screen.ready drops and the
//   whole pipeline holds until the output drains.
module camera_ray_direction (
	input  logic        clk,
	input  logic        arst_n,
	crd_screen_if.sink  screen,
	crd_ray_if.source   ray,
	crd_cfg_if.sink     cfg
);
	import crd_pkg::*;

	cfg_t   regs;
	logic   en;
	logic   fr_valid;
	nvec_t  fr_vec;
	logic   sq_valid;
	nvec_t  sq_vec;
	logic [ROOT_W-1:0] sq_root;
	logic   pv;
	ray_t   pd;

	logic   out_v_q, skid_v_q;
	ray_t   out_q, skid_q;

	crd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	crd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (screen.valid),
		.screen_x  (screen.screen_x),
		.screen_y  (screen.screen_y),
		.regs      (regs),
		.out_valid (fr_valid),
		.out_vec   (fr_vec)
	);

	crd_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_vec    (fr_vec),
		.out_valid (sq_valid),
		.out_vec   (sq_vec),
		.root      (sq_root)
	);

	crd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_vec    (sq_vec),
		.root      (sq_root),
		.out_valid (pv),
		.out_ray   (pd)
	);

	// Advance the pipeline while the skid register is free
	assign en           = !skid_v_q;
	assign screen.ready = en;

	// Hand results to the output register, park one in the skid on a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || ray.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q  <= pv;
			end
		end else if (pv && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || ray.ready)
			out_q <= skid_v_q ? skid_q : pd;
		else if (pv && en)
			skid_q <= pd;
	end

	assign ray.valid      = out_v_q;
	assign ray.dir_x      = out_q.dir_x;
	assign ray.dir_y      = out_q.dir_y;
	assign ray.dir_z      = out_q.dir_z;
	assign ray.degenerate = out_q.degenerate;

endmodule

// ----- src/crd_cfg_regs.sv -----
module crd_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	crd_cfg_if.sink       cfg,
	output crd_pkg::cfg_t regs
);
	import crd_pkg::*;

	cfg_t regs_q;

	// Always take writes
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Decode the register index; ignore indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.forward_vector  <= RST_FORWARD;
			regs_q.up_vector       <= RST_UP;
			regs_q.right_vector    <= RST_RIGHT;
			regs_q.half_width_tan  <= RST_HALF_W_TAN;
			regs_q.half_height_tan <= RST_HALF_H_TAN;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FORWARD:    regs_q.forward_vector  <= cfg.data;
				REG_UP:         regs_q.up_vector       <= cfg.data;
				REG_RIGHT:      regs_q.right_vector    <= cfg.data;
				REG_HALF_W_TAN: regs_q.half_width_tan  <= cfg.data[TAN_W-1:0];
				REG_HALF_H_TAN: regs_q.half_height_tan <= cfg.data[TAN_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- src/crd_front.sv -----
module crd_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic signed [crd_pkg::SCR_W-1:0] screen_x,
	input  logic signed [crd_pkg::SCR_W-1:0] screen_y,
	input  crd_pkg::cfg_t                  regs,
	output logic                           out_valid,
	output crd_pkg::nvec_t                 out_vec
);
	import crd_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic signed [TX_W-1:0]            tx_s1, ty_s1;
	logic signed [COMPONENT_WIDTH-1:0] f_s2  [N_COMP];
	logic signed [PROD_W-1:0]          rt_s2 [N_COMP];
	logic signed [PROD_W-1:0]          ut_s2 [N_COMP];
	logic signed [SUM_W-1:0]           sum_s3 [N_COMP];
	logic [WMAG_W-1:0]                 mag_s4 [N_COMP];
	logic [N_COMP-1:0]                 neg_s4, neg_s5, neg_s6, neg_s7;
	logic [WMAG_W-1:0]                 mag_s5 [N_COMP];
	logic [WMAG_W-1:0]                 mx_s5;
	logic [WMAG_W-1:0]                 mag_s6 [N_COMP];
	logic                              right_s6, degen_s6, degen_s7;
	logic [SH_W-1:0]                   amt_s6;
	logic [MAG_W-1:0]                  mag_s7 [N_COMP];

	logic signed [TX_W:0]      tx_full, ty_full;
	logic signed [SUM_W-1:0]   abs_c [N_COMP];
	logic [WMAG_W-1:0]         mx_c;
	logic [POS_W-1:0]          pos_c;
	logic                      exact_c, right_c;
	logic [SH_W-1:0]           amt_c;
	logic [WMAG_W-1:0]         t_c   [N_COMP];
	logic [MAG_W:0]            rnd_c [N_COMP];
	logic [MAG_W-1:0]          sh_c  [N_COMP];

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: scale screen position by the half-angle tangents
	always_comb begin
		tx_full = $signed({1'b0, regs.half_width_tan}) * screen_x;
		ty_full = $signed({1'b0, regs.half_height_tan}) * screen_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1 <= tx_full[TX_W-1:0];
			ty_s1 <= ty_full[TX_W-1:0];
		end
	end

	// Stage 2: multiply the right and up axes by the scaled position
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_COMP; i++) begin
				f_s2[i]  <= vec_comp(regs.forward_vector, i);
				rt_s2[i] <= PROD_W'(vec_comp(regs.right_vector, i)) * PROD_W'(tx_s1);
				ut_s2[i] <= PROD_W'(vec_comp(regs.up_vector, i)) * PROD_W'(ty_s1);
			end
		end
	end

	// Stage 3: add forward, right and up terms exactly
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_COMP; i++)
				sum_s3[i] <= (SUM_W'(f_s2[i]) <<< (2 * FRAC_BITS))
					+ SUM_W'(rt_s2[i]) + SUM_W'(ut_s2[i]);
		end
	end

	// Stage 4: split into sign and magnitude
	always_comb begin
		for (int i = 0; i < N_COMP; i++)
			abs_c[i] = sum_s3[i][SUM_W-1] ? -sum_s3[i] : sum_s3[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_COMP; i++) begin
				neg_s4[i] <= sum_s3[i][SUM_W-1];
				mag_s4[i] <= abs_c[i][WMAG_W-1:0];
			end
		end
	end

	// Stage 5: largest magnitude
	always_comb begin
		mx_c = mag_s4[0];
		for (int i = 1; i < N_COMP; i++)
			if (mag_s4[i] > mx_c)
				mx_c = mag_s4[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s5  <= mx_c;
			mag_s5 <= mag_s4;
			neg_s5 <= neg_s4;
		end
	end

	// Stage 6: find the leading one and pick the scaling shift
	always_comb begin
		pos_c = '0;
		for (int b = 0; b < WMAG_W; b++)
			if (mx_s5[b])
				pos_c = POS_W'(b);
		exact_c = (mx_s5 == (WMAG_W'(1) << (NORM_MSB + 1)));
		right_c = (pos_c >= POS_W'(NORM_MSB + 1)) && !exact_c;
		if (right_c)
			amt_c = SH_W'(pos_c - POS_W'(NORM_MSB + 1));
		else if (exact_c)
			amt_c = '0;
		else
			amt_c = SH_W'(POS_W'(NORM_MSB) - pos_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s6   <= mag_s5;
			neg_s6   <= neg_s5;
			right_s6 <= right_c;
			amt_s6   <= amt_c;
			degen_s6 <= (mx_s5 == '0);
		end
	end

	// Stage 7: scale so the largest magnitude has its top bit at NORM_MSB,
	// rounding half up when shifting right
	always_comb begin
		for (int i = 0; i < N_COMP; i++) begin
			t_c[i]   = mag_s6[i] >> amt_s6;
			rnd_c[i] = {1'b0, t_c[i][MAG_W-1:0]} + (MAG_W + 1)'(1);
			if (right_s6)
				sh_c[i] = rnd_c[i][MAG_W:1];
			else
				sh_c[i] = mag_s6[i][MAG_W-1:0] << amt_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s7   <= sh_c;
			neg_s7   <= neg_s6;
			degen_s7 <= degen_s6;
		end
	end

	assign out_valid = v_s7;

	always_comb begin
		for (int i = 0; i < N_COMP; i++)
			out_vec.mag[i] = mag_s7[i];
		out_vec.neg   = neg_s7;
		out_vec.degen = degen_s7;
	end

endmodule

// ----- src/crd_isqrt.sv -----
module crd_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  crd_pkg::nvec_t                in_vec,
	output logic                          out_valid,
	output crd_pkg::nvec_t                out_vec,
	output logic [crd_pkg::ROOT_W-1:0]    root
);
	import crd_pkg::*;

	// Squares stage, then one root bit per stage; index 0 holds the sum
	logic              v_s1;
	logic [SQ_W-1:0]   sq_s1 [N_COMP];
	nvec_t             vec_s1;

	logic              v_s   [ROOT_W+1];
	logic [SQ_W-1:0]   rem_s [ROOT_W+1];
	logic [SQ_W-1:0]   res_s [ROOT_W+1];
	nvec_t             vec_s [ROOT_W+1];

	// Square each scaled magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_COMP; i++)
				sq_s1[i] <= SQ_W'(in_vec.mag[i]) * SQ_W'(in_vec.mag[i]);
			vec_s1 <= in_vec;
		end
	end

	// Sum the squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= sq_s1[0] + sq_s1[1] + sq_s1[2];
			res_s[0] <= '0;
			vec_s[0] <= vec_s1;
		end
	end

	// Resolve one root bit per stage, high bit first
	for (genvar j = 0; j < ROOT_W; j++) begin : g_root
		localparam logic [SQ_W-1:0] BitVal = SQ_W'(1) << (2 * (ROOT_W - 1 - j));

		logic [SQ_W-1:0] trial;
		logic            take;

		always_comb begin
			trial = res_s[j] + BitVal;
			take  = (rem_s[j] >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[j+1] <= 1'b0;
			else if (en)
				v_s[j+1] <= v_s[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= take ? rem_s[j] - trial : rem_s[j];
				res_s[j+1] <= take ? (res_s[j] >> 1) + BitVal : res_s[j] >> 1;
				vec_s[j+1] <= vec_s[j];
			end
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_vec   = vec_s[ROOT_W];
	assign root      = res_s[ROOT_W][ROOT_W-1:0];

endmodule

// ----- src/crd_div.sv -----
module crd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  crd_pkg::nvec_t             in_vec,
	input  logic [crd_pkg::ROOT_W-1:0] root,
	output logic                       out_valid,
	output crd_pkg::ray_t              out_ray
);
	import crd_pkg::*;

	localparam logic [QUO_W-1:0] QOne = QUO_W'(1) << FRAC_BITS;

	// Index 0 holds the prepared numerators, then one quotient bit per stage
	logic              v_s   [QUO_W+1];
	logic [NUM_W-1:0]  rem_s [QUO_W+1][N_COMP];
	logic [QUO_W-1:0]  quo_s [QUO_W+1][N_COMP];
	logic [ROOT_W-1:0] den_s [QUO_W+1];
	logic [N_COMP-1:0] neg_s [QUO_W+1];
	logic              degen_s [QUO_W+1];

	logic              v_sfin;
	ray_t              ray_sfin;

	logic [ROOT_W-1:0] den_c;
	logic [QUO_W-1:0]  qsat_c [N_COMP];
	logic [COMPONENT_WIDTH-1:0] qext_c [N_COMP];
	comp_t             dir_c  [N_COMP];

	// Form the rounded numerators; guard the divisor against zero
	always_comb begin
		den_c = (root == '0) ? ROOT_W'(1) : root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (en)
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_COMP; i++) begin
				rem_s[0][i] <= (NUM_W'(in_vec.mag[i]) << FRAC_BITS) + NUM_W'(den_c >> 1);
				quo_s[0][i] <= '0;
			end
			den_s[0]   <= den_c;
			neg_s[0]   <= in_vec.neg;
			degen_s[0] <= in_vec.degen;
		end
	end

	// Restoring division, high quotient bit first
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int QBit = QUO_W - 1 - k;

		logic [NUM_W-1:0] dsh;
		logic [N_COMP-1:0] take;

		always_comb begin
			dsh = NUM_W'(den_s[k]) << QBit;
			for (int i = 0; i < N_COMP; i++)
				take[i] = (rem_s[k][i] >= dsh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else if (en)
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < N_COMP; i++) begin
					rem_s[k+1][i] <= take[i] ? rem_s[k][i] - dsh : rem_s[k][i];
					quo_s[k+1][i] <= quo_s[k][i] | (QUO_W'(take[i]) << QBit);
				end
				den_s[k+1]   <= den_s[k];
				neg_s[k+1]   <= neg_s[k];
				degen_s[k+1] <= degen_s[k];
			end
		end
	end

	// Saturate to one, reapply the sign, zero a degenerate vector
	always_comb begin
		for (int i = 0; i < N_COMP; i++) begin
			qsat_c[i] = (quo_s[QUO_W][i] > QOne) ? QOne : quo_s[QUO_W][i];
			qext_c[i] = COMPONENT_WIDTH'(qsat_c[i]);
			if (degen_s[QUO_W])
				dir_c[i] = '0;
			else if (neg_s[QUO_W][i])
				dir_c[i] = comp_t'(-qext_c[i]);
			else
				dir_c[i] = comp_t'(qext_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_sfin <= 1'b0;
		else if (en)
			v_sfin <= v_s[QUO_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_sfin.dir_x      <= dir_c[0];
			ray_sfin.dir_y      <= dir_c[1];
			ray_sfin.dir_z      <= dir_c[2];
			ray_sfin.degenerate <= degen_s[QUO_W];
		end
	end

	assign out_valid = v_sfin;
	assign out_ray   = ray_sfin;

endmodule

// ----- src/crd_checker.sv -----
`include "camera_ray_direction_macros.svh"

module crd_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   ray_valid,
	input logic                                   ray_ready,
	input logic signed [crd_pkg::COMPONENT_WIDTH-1:0] dir_x,
	input logic signed [crd_pkg::COMPONENT_WIDTH-1:0] dir_y,
	input logic signed [crd_pkg::COMPONENT_WIDTH-1:0] dir_z,
	input logic                                   degenerate
);
	import crd_pkg::*;

	localparam int DirOne = 1 << FRAC_BITS;

	// Hold a stalled result
	`CRD_ASSERT_NEXT(a_ray_hold, ray_valid && !ray_ready, ray_valid, "ray valid dropped while stalled")
	`CRD_ASSERT_NEXT(a_ray_stable, ray_valid && !ray_ready, $stable(dir_x) && $stable(dir_y) && $stable(dir_z) && $stable(degenerate), "ray payload changed while stalled")

	// A zero-length sum gives a zero vector
	`CRD_ASSERT_NOW(a_degen_zero, ray_valid && degenerate, dir_x == 0 && dir_y == 0 && dir_z == 0, "degenerate ray with nonzero direction")

	// A normal result stays within unit range and is never all zero
	`CRD_ASSERT_NOW(a_unit_range, ray_valid && !degenerate, dir_x >= -DirOne && dir_x <= DirOne && dir_y >= -DirOne && dir_y <= DirOne && dir_z >= -DirOne && dir_z <= DirOne && (dir_x != 0 || dir_y != 0 || dir_z != 0), "direction out of unit range")

endmodule

bind camera_ray_direction crd_checker u_crd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.ray_valid  (ray.valid),
	.ray_ready  (ray.ready),
	.dir_x      (ray.dir_x),
	.dir_y      (ray.dir_y),
	.dir_z      (ray.dir_z),
	.degenerate (ray.degenerate)
);
